/* sv/crl_pkg.sv */
// Shared types and constants for the circular ring list engine.
// Used by crl_ctrl, crl_dpath and circular_ring_list_engine_unit; no dependencies.
`default_nettype none

package crl_pkg;

   // Ring sizing
   localparam int CAPACITY   = 256;
   localparam int VALUE_BITS = 32;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);

   // Field widths
   localparam int CMD_W    = 3;
   localparam int STEPS_W  = 16;
   localparam int STATUS_W = 2;
   localparam int OUT_W    = 32;
   localparam int BITCNT_W = $clog2(STEPS_W + 1);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT  = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_EXTRACT = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_ROTATE  = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_SEARCH  = CMD_W'(3);
   localparam logic [CMD_W-1:0] CMD_DELETE  = CMD_W'(4);

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_FULL  = STATUS_W'(2);

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic signed [31:0] value;
      logic [STEPS_W-1:0] steps;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic signed [31:0]  value_out;
      logic                found;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   // Datapath micro-operations, one per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_INS_READ,
      OP_INS_WRITE,
      OP_INS_LINK,
      OP_READ_CUR,
      OP_READ_LINK,
      OP_TAKE,
      OP_FIND_START,
      OP_STEP,
      OP_RESTORE,
      OP_DIV,
      OP_ROT_START,
      OP_ROT_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic                publish;
      logic [STATUS_W-1:0] pub_status;
      logic                pub_found;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             count_zero;
      logic             count_full;
      logic             match;
      logic             last;
      logic             div_done;
      logic             rem_zero;
      logic             out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* sv/crl_ctrl.sv */
// Sequencer for the circular ring list engine: one micro-op per cycle.
// Depends on crl_pkg; drives crl_dpath through ctrl_cmd_type.
`default_nettype none

module crl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire crl_pkg::dp_status_type status,
   output crl_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_WRITE,
      S_INS_LINK,
      S_X_LINK,
      S_TAKE,
      S_F_LINK,
      S_WALK,
      S_DIV,
      S_ROT_WALK,
      S_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [crl_pkg::STATUS_W-1:0]    pub_status_ff, pub_status_in;
   logic                            pub_found_ff, pub_found_in;

   always_comb begin
      state_in       = state_ff;
      pub_status_in  = pub_status_ff;
      pub_found_in   = pub_found_ff;
      cmd.op         = crl_pkg::OP_NONE;
      cmd.publish    = 1'b0;
      cmd.pub_status = pub_status_ff;
      cmd.pub_found  = pub_found_ff;
      req_stall      = 1'b1;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op        = crl_pkg::OP_LOAD;
               pub_status_in = crl_pkg::STATUS_OK;
               pub_found_in  = 1'b0;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.cmd)
               crl_pkg::CMD_INSERT: begin
                  if (status.count_full) begin
                     pub_status_in = crl_pkg::STATUS_FULL;
                     state_in      = S_DONE;
                  end else begin
                     cmd.op   = crl_pkg::OP_INS_READ;
                     state_in = S_INS_WRITE;
                  end
               end
               crl_pkg::CMD_EXTRACT: begin
                  if (status.count_zero) begin
                     pub_status_in = crl_pkg::STATUS_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     cmd.op   = crl_pkg::OP_READ_CUR;
                     state_in = S_X_LINK;
                  end
               end
               crl_pkg::CMD_ROTATE: begin
                  if (status.count_zero) begin
                     pub_status_in = crl_pkg::STATUS_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     cmd.op   = crl_pkg::OP_DIV;
                     state_in = S_DIV;
                  end
               end
               crl_pkg::CMD_SEARCH, crl_pkg::CMD_DELETE: begin
                  if (status.count_zero) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.op   = crl_pkg::OP_FIND_START;
                     state_in = S_F_LINK;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_INS_WRITE: begin
            cmd.op   = crl_pkg::OP_INS_WRITE;
            state_in = S_INS_LINK;
         end
         S_INS_LINK: begin
            cmd.op   = crl_pkg::OP_INS_LINK;
            state_in = S_DONE;
         end
         S_X_LINK: begin
            cmd.op   = crl_pkg::OP_READ_LINK;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            cmd.op   = crl_pkg::OP_TAKE;
            state_in = S_DONE;
         end
         S_F_LINK: begin
            cmd.op   = crl_pkg::OP_READ_LINK;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (status.match) begin
               // node after cursor holds the key; delete unlinks it right here
               pub_found_in = 1'b1;
               if (status.cmd == crl_pkg::CMD_DELETE) begin
                  cmd.op = crl_pkg::OP_TAKE;
               end
               state_in = S_DONE;
            end else if (status.last) begin
               cmd.op   = crl_pkg::OP_RESTORE;
               state_in = S_DONE;
            end else begin
               cmd.op = crl_pkg::OP_STEP;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  state_in = S_DONE;
               end else begin
                  cmd.op   = crl_pkg::OP_ROT_START;
                  state_in = S_ROT_WALK;
               end
            end else begin
               cmd.op = crl_pkg::OP_DIV;
            end
         end
         S_ROT_WALK: begin
            cmd.op = crl_pkg::OP_ROT_STEP;
            if (status.last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pub_status_ff <= crl_pkg::STATUS_OK;
         pub_found_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pub_status_ff <= pub_status_in;
         pub_found_ff  <= pub_found_in;
      end
   end

   // result only goes out when the output register can take it
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> status.out_free)
      else $error("result published into a busy output register");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !status.count_zero)
      else $error("search walk on an empty ring");

   a_rot_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT_WALK) |-> (!status.count_zero && !status.rem_zero))
      else $error("rotate walk with nothing to walk");

endmodule

`default_nettype wire

/* sv/crl_dpath.sv */
// Datapath of the circular ring list engine: value, link and free-slot stores,
// cursor and count, remainder unit and the output register. Depends on crl_pkg.
`default_nettype none

module crl_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crl_pkg::req_type      req_data,
   input  wire crl_pkg::ctrl_cmd_type cmd,
   output crl_pkg::dp_status_type     status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output crl_pkg::rsp_type           rsp_data
);

   // stores
   logic [crl_pkg::VALUE_BITS-1:0] value_mem [crl_pkg::CAPACITY];
   logic [crl_pkg::SLOT_W-1:0]     link_mem  [crl_pkg::CAPACITY];
   logic [crl_pkg::SLOT_W-1:0]     stack_mem [crl_pkg::CAPACITY];

   // control state
   logic [crl_pkg::SLOT_W-1:0]     cursor_ff, cursor_in;
   logic [crl_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [crl_pkg::COUNT_W-1:0]    top_ff, top_in;
   logic [crl_pkg::COUNT_W-1:0]    lowmark_ff, lowmark_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [crl_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [crl_pkg::VALUE_BITS-1:0] key_ff, key_in;
   logic [crl_pkg::STEPS_W-1:0]    steps_ff, steps_in;
   logic [crl_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [crl_pkg::SLOT_W-1:0]     start_ff, start_in;
   logic [crl_pkg::COUNT_W-1:0]    walk_ff, walk_in;
   logic [crl_pkg::COUNT_W-1:0]    rem_ff, rem_in;
   logic [crl_pkg::BITCNT_W-1:0]   bitcnt_ff, bitcnt_in;
   logic [crl_pkg::OUT_W-1:0]      vout_ff, vout_in;
   crl_pkg::rsp_type               rsp_ff, rsp_in;

   // registered memory read data
   logic [crl_pkg::SLOT_W-1:0]     link_rd_ff;
   logic [crl_pkg::VALUE_BITS-1:0] value_rd_ff;
   logic [crl_pkg::SLOT_W-1:0]     stack_rd_ff;
   logic [crl_pkg::SLOT_W-1:0]     stack_pos_ff;

   logic                           rd_en;
   logic [crl_pkg::SLOT_W-1:0]     rd_addr;
   logic                           link_we;
   logic [crl_pkg::SLOT_W-1:0]     link_wa, link_wd;
   logic                           value_we;
   logic                           stack_re, stack_we;
   logic [crl_pkg::COUNT_W-1:0]    top_dec;
   logic [crl_pkg::SLOT_W-1:0]     new_slot;
   logic [crl_pkg::COUNT_W:0]      div_trial, div_diff;
   logic                           div_ge;
   logic                           count_zero, count_full;

   assign count_zero = (count_ff == '0);
   assign count_full = (count_ff >= crl_pkg::COUNT_W'(crl_pkg::CAPACITY)) || (top_ff == '0);
   assign top_dec    = top_ff - crl_pkg::COUNT_W'(1);

   // stack positions below the low-water mark were never written: they hold reset order
   assign new_slot = (crl_pkg::COUNT_W'(stack_pos_ff) >= lowmark_ff) ? stack_rd_ff :
                     (crl_pkg::SLOT_W'(crl_pkg::CAPACITY - 1) - stack_pos_ff);

   // one restoring remainder step per cycle, MSB of steps first
   assign div_trial = {rem_ff, steps_ff[crl_pkg::STEPS_W-1]};
   assign div_ge    = (div_trial >= {1'b0, count_ff});
   assign div_diff  = div_trial - {1'b0, count_ff};

   always_comb begin
      rd_en    = 1'b0;
      rd_addr  = cursor_ff;
      stack_re = 1'b0;
      stack_we = 1'b0;
      value_we = 1'b0;
      link_we  = 1'b0;
      link_wa  = cursor_ff;
      link_wd  = link_rd_ff;

      cursor_in    = cursor_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      lowmark_in   = lowmark_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      steps_in     = steps_ff;
      slot_in      = slot_ff;
      start_in     = start_ff;
      walk_in      = walk_ff;
      rem_in       = rem_ff;
      bitcnt_in    = bitcnt_ff;
      vout_in      = vout_ff;

      case (cmd.op)
         crl_pkg::OP_LOAD: begin
            cmd_in    = req_data.command;
            key_in    = crl_pkg::VALUE_BITS'($signed(req_data.value));
            steps_in  = req_data.steps;
            vout_in   = '0;
            rem_in    = '0;
            bitcnt_in = '0;
         end
         crl_pkg::OP_INS_READ: begin
            rd_en    = 1'b1;
            stack_re = 1'b1;
         end
         crl_pkg::OP_INS_WRITE: begin
            value_we   = 1'b1;
            link_we    = 1'b1;
            link_wa    = new_slot;
            link_wd    = count_zero ? new_slot : link_rd_ff;
            slot_in    = new_slot;
         end
         crl_pkg::OP_INS_LINK: begin
            // stack pop lands with the count bump so the slot books stay balanced
            link_we    = !count_zero;
            link_wa    = cursor_ff;
            link_wd    = slot_ff;
            cursor_in  = slot_ff;
            count_in   = count_ff + crl_pkg::COUNT_W'(1);
            top_in     = top_dec;
            lowmark_in = (top_dec < lowmark_ff) ? top_dec : lowmark_ff;
         end
         crl_pkg::OP_READ_CUR: begin
            rd_en = 1'b1;
         end
         crl_pkg::OP_READ_LINK: begin
            rd_en   = 1'b1;
            rd_addr = link_rd_ff;
            slot_in = link_rd_ff;
         end
         crl_pkg::OP_TAKE: begin
            // slot_ff is the node after the cursor, link_rd_ff its successor
            vout_in = crl_pkg::OUT_W'($signed(value_rd_ff));
            if (count_ff > crl_pkg::COUNT_W'(1)) begin
               link_we  = 1'b1;
               link_wa  = cursor_ff;
               link_wd  = link_rd_ff;
               count_in = count_ff - crl_pkg::COUNT_W'(1);
            end else begin
               count_in = '0;
            end
            if (top_ff < crl_pkg::COUNT_W'(crl_pkg::CAPACITY)) begin
               stack_we = 1'b1;
               top_in   = top_ff + crl_pkg::COUNT_W'(1);
            end
         end
         crl_pkg::OP_FIND_START: begin
            rd_en    = 1'b1;
            start_in = cursor_ff;
            walk_in  = count_ff;
         end
         crl_pkg::OP_STEP: begin
            rd_en     = 1'b1;
            rd_addr   = link_rd_ff;
            cursor_in = slot_ff;
            slot_in   = link_rd_ff;
            walk_in   = walk_ff - crl_pkg::COUNT_W'(1);
         end
         crl_pkg::OP_RESTORE: begin
            cursor_in = start_ff;
         end
         crl_pkg::OP_DIV: begin
            rem_in    = div_ge ? div_diff[crl_pkg::COUNT_W-1:0] :
                                 div_trial[crl_pkg::COUNT_W-1:0];
            steps_in  = {steps_ff[crl_pkg::STEPS_W-2:0], 1'b0};
            bitcnt_in = bitcnt_ff + crl_pkg::BITCNT_W'(1);
         end
         crl_pkg::OP_ROT_START: begin
            rd_en   = 1'b1;
            walk_in = rem_ff;
         end
         crl_pkg::OP_ROT_STEP: begin
            rd_en     = 1'b1;
            rd_addr   = link_rd_ff;
            cursor_in = link_rd_ff;
            walk_in   = walk_ff - crl_pkg::COUNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.publish) begin
         rsp_in.status    = cmd.pub_status;
         rsp_in.value_out = vout_ff;
         rsp_in.found     = cmd.pub_found;
         rsp_in.count     = count_ff;
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         count_ff     <= '0;
         top_ff       <= crl_pkg::COUNT_W'(crl_pkg::CAPACITY);
         lowmark_ff   <= crl_pkg::COUNT_W'(crl_pkg::CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         lowmark_ff   <= lowmark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      steps_ff  <= steps_in;
      slot_ff   <= slot_in;
      start_ff  <= start_in;
      walk_ff   <= walk_in;
      rem_ff    <= rem_in;
      bitcnt_ff <= bitcnt_in;
      vout_ff   <= vout_in;
      rsp_ff    <= rsp_in;
   end

   // value and link stores: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[new_slot] <= key_ff;
      end
      if (rd_en) begin
         value_rd_ff <= value_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (rd_en) begin
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   // free-slot stack
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[top_ff[crl_pkg::SLOT_W-1:0]] <= slot_ff;
      end
      if (stack_re) begin
         stack_rd_ff  <= stack_mem[top_dec[crl_pkg::SLOT_W-1:0]];
         stack_pos_ff <= top_dec[crl_pkg::SLOT_W-1:0];
      end
   end

   always_comb begin
      status.cmd        = cmd_ff;
      status.count_zero = count_zero;
      status.count_full = count_full;
      status.match      = (value_rd_ff == key_ff);
      status.last       = (walk_ff == crl_pkg::COUNT_W'(1));
      status.div_done   = (bitcnt_ff == crl_pkg::BITCNT_W'(crl_pkg::STEPS_W));
      status.rem_zero   = (rem_ff == '0);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every slot is either in the ring or on the free stack
   a_slots_conserved: assert property (@(posedge clock) disable iff (reset)
      ((crl_pkg::COUNT_W+1)'(count_ff) + (crl_pkg::COUNT_W+1)'(top_ff))
         == (crl_pkg::COUNT_W+1)'(crl_pkg::CAPACITY))
      else $error("ring count and free stack depth disagree");

   a_lowmark: assert property (@(posedge clock) disable iff (reset)
      lowmark_ff <= top_ff)
      else $error("stack low-water mark above stack top");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == crl_pkg::OP_TAKE) |-> !count_zero)
      else $error("node removed from an empty ring");

endmodule

`default_nettype wire

/* sv/circular_ring_list_engine_unit.sv */
// Top level of the circular ring list engine.
// Depends on crl_pkg, crl_ctrl and crl_dpath.
`default_nettype none

// A bounded circular list of up to 256 signed 32-bit values with a cursor on
// the last node. One command per request beat, one response beat per command:
// insert, extract, rotate, search and delete-by-value, with a status code and
// the ring count after the command. Commands run one at a time; a finished
// response sits in an output register so the next request is taken while it
// waits. Insert reads the free stack, writes the node, then links it after the
// cursor; extract reads the cursor's link and the next node, then unlinks it;
// search and delete walk the ring one node at a time, up to the ring count;
// rotate forms steps mod count in a one-bit-per-cycle remainder unit, then
// walks that many nodes; error cases and unknown codes go straight to the
// response. The next request is taken the cycle after the response is
// registered. No clearing pass after reset: free slots are tracked with a
// low-water mark on the free stack, and no unwritten store entry is ever used.
module circular_ring_list_engine_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire crl_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output crl_pkg::rsp_type      rsp_data
);

   crl_pkg::ctrl_cmd_type  ctrl_cmd;
   crl_pkg::dp_status_type dp_status;

   // sequencer: one micro-op per cycle
   crl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // stores, cursor, counters and the response register
   crl_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
